// ===== rtl/tcpl_pkg.sv =====
// Package for the two-class priority list: sizes, codes and the cell control types.
// Used by every module of the block; depends on nothing.
package tcpl_pkg;

  localparam int DEPTH     = 128;
  localparam int TAG_WIDTH = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;

  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_UPD  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic prio;
    tag_t tag;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     at;
    entry_t   new_entry;
    cnt_t     count;
    logic     tok_start;
    logic     tok_clr;
  } cell_ctl_t;

endpackage

// ===== rtl/tcpl_cell.sv =====
// One list slot: holds an entry, a search token and a stage of the read return line.
// Depends on tcpl_pkg.
module tcpl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tcpl_pkg::idx_t     cell_idx,
  input  tcpl_pkg::cell_ctl_t ctl,
  input  tcpl_pkg::entry_t   left_entry,
  input  tcpl_pkg::entry_t   right_entry,
  output tcpl_pkg::entry_t   entry_out,
  input  logic               tok_in,
  output logic               tok_out,
  input  tcpl_pkg::entry_t   ret_in,
  output tcpl_pkg::entry_t   ret_out,
  output logic               stop
);
  import tcpl_pkg::*;

  entry_t entry_r, entry_nxt;
  entry_t ret_r, ret_nxt;
  logic   tok_r, tok_nxt;
  logic   at_here, past_at, beyond_count;

  assign at_here      = (cell_idx == ctl.at);
  assign past_at      = (cell_idx > ctl.at);
  assign beyond_count = (cnt_t'(cell_idx) >= ctl.count);

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_INS: begin
        if (at_here) begin
          entry_nxt = ctl.new_entry;
        end else if (past_at) begin
          entry_nxt = left_entry;
        end
      end
      CELL_DEL: begin
        if (at_here || past_at) begin
          entry_nxt = right_entry;
        end
      end
      CELL_UPD: begin
        if (at_here) begin
          entry_nxt = ctl.new_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  assign tok_nxt = ctl.tok_clr ? 1'b0 : tok_in;
  assign ret_nxt = at_here ? entry_r : ret_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    ret_r   <= ret_nxt;
  end

  assign entry_out = entry_r;
  assign tok_out   = tok_r;
  assign ret_out   = ret_r;
  assign stop      = tok_r & (beyond_count | ~entry_r.prio);

endmodule

// ===== rtl/tcpl_chain.sv =====
// The row of list cells with neighbour links, the search hit and the read return output.
// Depends on tcpl_pkg and tcpl_cell.
module tcpl_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  tcpl_pkg::cell_ctl_t ctl,
  output logic                hit,
  output tcpl_pkg::entry_t    rd_entry
);
  import tcpl_pkg::*;

  entry_t             ent_q [DEPTH];
  entry_t             ret_q [DEPTH];
  logic [DEPTH-1:0]   tok_q;
  logic [DEPTH-1:0]   stop_q;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    entry_t left_e, right_e, ret_i;
    logic   tok_i;

    if (j == 0) begin : g_head
      assign left_e = '0;
      assign tok_i  = ctl.tok_start;
    end else begin : g_body
      assign left_e = ent_q[j-1];
      assign tok_i  = tok_q[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      assign right_e = '0;
      assign ret_i   = '0;
    end else begin : g_inner
      assign right_e = ent_q[j+1];
      assign ret_i   = ret_q[j+1];
    end

    tcpl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (idx_t'(j)),
      .ctl         (ctl),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry_out   (ent_q[j]),
      .tok_in      (tok_i),
      .tok_out     (tok_q[j]),
      .ret_in      (ret_i),
      .ret_out     (ret_q[j]),
      .stop        (stop_q[j])
    );
  end

  assign hit      = |stop_q;
  assign rd_entry = ret_q[0];

endmodule

// ===== rtl/two_class_priority_list.sv =====
// Top level of the two-class priority list: request decoding, sequencer and result register.
// Depends on tcpl_pkg and tcpl_chain.
// A high insert, a delete, an update or a rejected request is answered from idle; a low insert waits
// for the token walk to find its place, a read for the entry at its 1-based position to come down the return line.
// One request is in work at a time; the next one is taken in the cycle its result is shown.
// Synchronous active-low reset clears count, sequencer and tokens; the receiver cannot stall.
module two_class_priority_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic        in_priority_high,
  input  logic [15:0] in_entry_tag,
  input  logic [7:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic        out_priority,
  output logic [7:0]  out_entry_count
);
  import tcpl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_READ
  } state_t;

  state_t    state_r, state_nxt;
  cnt_t      count_r, count_nxt;
  cnt_t      step_r, step_nxt;
  idx_t      at_r, at_nxt;
  entry_t    req_r, req_nxt;
  logic      out_valid_r, out_valid_nxt;
  status_t   status_r, status_nxt;
  entry_t    res_r, res_nxt;
  cell_ctl_t ctl;
  logic      hit;
  entry_t    rd_entry;
  cmp_t      pos_c, cnt_c;
  idx_t      pos_at;
  entry_t    in_entry;

  assign pos_c    = cmp_t'(in_position);
  assign cnt_c    = cmp_t'(count_r);
  assign pos_at   = idx_t'(pos_c - cmp_t'(1));
  assign in_entry = '{prio: in_priority_high, tag: tag_t'(in_entry_tag)};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    at_nxt        = at_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    res_nxt       = res_r;
    ctl           = '{op: CELL_HOLD, at: at_r, new_entry: req_r, count: count_r,
                      tok_start: 1'b0, tok_clr: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt    = '0;
          status_nxt = ST_OK;
          if (op_t'(in_opcode) == OP_INSERT) begin
            if (count_r == cnt_t'(DEPTH)) begin
              status_nxt    = ST_FULL;
              out_valid_nxt = 1'b1;
            end else if (in_priority_high) begin
              ctl.op        = CELL_INS;
              ctl.at        = '0;
              ctl.new_entry = in_entry;
              count_nxt     = count_r + cnt_t'(1);
              out_valid_nxt = 1'b1;
            end else begin
              req_nxt       = in_entry;
              step_nxt      = '0;
              ctl.tok_start = 1'b1;
              state_nxt     = S_SRCH;
            end
          end else if (count_r == '0) begin
            status_nxt    = ST_EMPTY;
            out_valid_nxt = 1'b1;
          end else if (pos_c == '0 || pos_c > cnt_c) begin
            status_nxt    = ST_RANGE;
            out_valid_nxt = 1'b1;
          end else begin
            case (op_t'(in_opcode))
              OP_DELETE: begin
                ctl.op        = CELL_DEL;
                ctl.at        = pos_at;
                count_nxt     = count_r - cnt_t'(1);
                out_valid_nxt = 1'b1;
              end
              OP_UPDATE: begin
                ctl.op        = CELL_UPD;
                ctl.at        = pos_at;
                ctl.new_entry = in_entry;
                out_valid_nxt = 1'b1;
              end
              default: begin
                at_nxt    = pos_at;
                step_nxt  = cnt_t'(pos_c);
                state_nxt = S_READ;
              end
            endcase
          end
        end
      end
      S_SRCH: begin
        if (hit) begin
          ctl.op        = CELL_INS;
          ctl.at        = idx_t'(step_r);
          ctl.tok_clr   = 1'b1;
          count_nxt     = count_r + cnt_t'(1);
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          step_nxt = step_r + cnt_t'(1);
        end
      end
      S_READ: begin
        if (step_r == '0) begin
          res_nxt       = rd_entry;
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          step_nxt = step_r - cnt_t'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    at_r     <= at_nxt;
    req_r    <= req_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  tcpl_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .hit      (hit),
    .rd_entry (rd_entry)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_tag         = 16'(res_r.tag);
  assign out_priority    = res_r.prio;
  assign out_entry_count = 8'(count_r);

`ifndef SYNTHESIS
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe raised while a request is still in work");

  a_request_progresses: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request neither answered nor in work");

  a_failed_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_tag == '0 && out_priority == 1'b0))
    else $error("rejected request returned entry data");

  a_full_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (count_r == cnt_t'(DEPTH)))
    else $error("full status reported below capacity");
`endif

endmodule
